// ===== src/wavetable_2d_bilinear_lookup_top_assert.svh =====
// Assertion macros shared by the wavetable lookup modules.
// Defining ASSERT_OFF removes every assertion that uses them.
`ifndef WAVETABLE_2D_BILINEAR_LOOKUP_TOP_ASSERT_SVH
`define WAVETABLE_2D_BILINEAR_LOOKUP_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is high.
`define WT2D_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled while reset is high.
`define WT2D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define WT2D_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define WT2D_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== src/wt2d_pkg.sv =====
`timescale 1ns / 1ps
package wt2d_pkg;

   // Field widths of the ports.
   localparam int ROW_W      = 4;
   localparam int COL_W      = 10;
   localparam int SAMPLE_W   = 16;
   localparam int POSX_W     = 26;
   localparam int POSZ_W     = 17;
   localparam int FRAC_W     = 16;
   localparam int STATUS_W   = 2;
   localparam int FRAMES_W   = 11;
   localparam int ROWS_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // Four neighbours are read for every lookup.
   localparam int TAPS = 4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS   = 2'd2;

   // Interpolation modes.
   localparam logic MODE_NEAREST = 1'b0;
   localparam logic MODE_LINEAR  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_WRITE = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   // Effective (already clamped) configuration.
   typedef struct packed {
      logic                mode;
      logic [FRAMES_W-1:0] frames;
      logic [ROWS_W-1:0]   rows;
   } cfg_type;

   // Control that travels with each item through the blend stages.
   typedef struct packed {
      status_type         status;
      logic [FRAC_W-1:0]  fx;
      logic [FRAC_W-1:0]  fz;
   } ctrl_type;

endpackage

// ===== src/wt2d_ram.sv =====
`timescale 1ns / 1ps
module wt2d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/wt2d_front.sv =====
`timescale 1ns / 1ps
`include "wavetable_2d_bilinear_lookup_top_assert.svh"
module wt2d_front #(
   parameter int MAX_FRAMES = 1024,
   parameter int MAX_ROWS = 16,
   localparam int ADDR_W = $clog2(MAX_FRAMES * MAX_ROWS)
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  wt2d_pkg::cfg_type                         cfg,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic                                      req_operation,
   input  logic [wt2d_pkg::ROW_W-1:0]                req_write_row,
   input  logic [wt2d_pkg::COL_W-1:0]                req_write_column,
   input  logic signed [wt2d_pkg::SAMPLE_W-1:0]      req_write_value,
   input  logic [wt2d_pkg::POSX_W-1:0]               req_position_x,
   input  logic [wt2d_pkg::POSZ_W-1:0]               req_position_z,
   output logic                                      a_valid,
   input  logic                                      a_ready,
   output logic                                      wr_req,
   output logic [ADDR_W-1:0]                         wr_addr,
   output logic [wt2d_pkg::SAMPLE_W-1:0]             wr_data,
   output logic [wt2d_pkg::TAPS-1:0][ADDR_W-1:0]     rd_addr,
   output wt2d_pkg::ctrl_type                        a_ctrl
);

   import wt2d_pkg::*;

   localparam int DEPTH = MAX_FRAMES * MAX_ROWS;
   localparam logic OP_WRITE = 1'b0;
   localparam logic [POSZ_W-1:0] Z_ONE = 17'h10000;
   localparam int ZS_W = POSZ_W + 4;

   // Input side: saturate z, scale it, split x and derive the neighbour frames.
   logic [POSZ_W-1:0]      pz_sat;
   logic [ZS_W:0]          zs_full;
   logic [ZS_W-1:0]        zs_in;
   logic [FRAMES_W-1:0]    xi_in;
   logic [FRAMES_W-1:0]    xp1;
   logic [FRAMES_W-1:0]    xn_in;
   logic [POSX_W:0]        xr_sum;
   logic [FRAMES_W-1:0]    xr_raw;
   logic [FRAMES_W-1:0]    xr_in;
   logic                   range_in;

   assign pz_sat   = (req_position_z > Z_ONE) ? Z_ONE : req_position_z;
   assign zs_full  = {5'b0, pz_sat} * {17'b0, (cfg.rows - 5'd1)};
   assign zs_in    = zs_full[ZS_W-1:0];
   assign xi_in    = {1'b0, req_position_x[POSX_W-1:FRAC_W]};
   assign range_in = (xi_in >= cfg.frames);
   assign xp1      = xi_in + 11'd1;
   assign xn_in    = (xp1 >= cfg.frames) ? '0 : xp1;
   assign xr_sum   = {1'b0, req_position_x} + 27'h8000;
   assign xr_raw   = xr_sum[POSX_W:FRAC_W];
   assign xr_in    = (xr_raw >= cfg.frames) ? '0 : xr_raw;

   logic                   a_valid_ff;
   logic                   op_ff;
   logic [ROW_W-1:0]       wrow_ff;
   logic [COL_W-1:0]       wcol_ff;
   logic [SAMPLE_W-1:0]    wval_ff;
   logic [FRAMES_W-1:0]    xi_ff;
   logic [FRAMES_W-1:0]    xn_ff;
   logic [FRAMES_W-1:0]    xr_ff;
   logic [FRAC_W-1:0]      fx_ff;
   logic [ZS_W-1:0]        zs_ff;
   logic                   range_ff;

   assign req_ready = !a_valid_ff || a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_ready) begin
         a_valid_ff <= req_valid;
      end
      if (req_ready) begin
         op_ff    <= req_operation;
         wrow_ff  <= req_write_row;
         wcol_ff  <= req_write_column;
         wval_ff  <= req_write_value;
         xi_ff    <= xi_in;
         xn_ff    <= xn_in;
         xr_ff    <= xr_in;
         fx_ff    <= req_position_x[FRAC_W-1:0];
         zs_ff    <= zs_in;
         range_ff <= range_in;
      end
   end

   // Address side. The scaled z never exceeds rows-1 in its integer part,
   // so the row wrap on the base row is a no-op.
   logic [ROWS_W-1:0]      zi;
   logic [ZS_W-1:0]        zr_sum;
   logic [ROWS_W-1:0]      zr_near;
   logic [ROWS_W-1:0]      zp1;
   logic [ROWS_W-1:0]      zn;
   logic [ROWS_W-1:0]      row0;
   logic [ROWS_W-1:0]      row1;
   logic [FRAMES_W-1:0]    col0;
   logic [FRAMES_W-1:0]    col1;
   logic                   in_bounds;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [ROWS_W-1:0] row,
                                                 input logic [FRAMES_W-1:0] col);
      addr_of = ADDR_W'(32'(row) * MAX_FRAMES + 32'(col));
   endfunction

   assign zi      = zs_ff[ZS_W-1:FRAC_W];
   assign zr_sum  = zs_ff + 21'h8000;
   assign zr_near = zr_sum[ZS_W-1:FRAC_W];
   assign zp1     = zi + 5'd1;
   assign zn      = (zp1 >= cfg.rows) ? '0 : zp1;

   assign row0 = (cfg.mode == MODE_LINEAR) ? zi : zr_near;
   assign col0 = range_ff ? '0 : ((cfg.mode == MODE_LINEAR) ? xi_ff : xr_ff);

   // In nearest mode every tap reads the rounded entry, so the taps that get
   // zero weight never touch an entry the lookup does not own.
   assign row1 = (cfg.mode == MODE_LINEAR) ? zn : row0;
   assign col1 = (cfg.mode == MODE_LINEAR) ? xn_ff : col0;

   assign rd_addr[0] = addr_of(row0, col0);
   assign rd_addr[1] = addr_of(row0, col1);
   assign rd_addr[2] = addr_of(row1, col0);
   assign rd_addr[3] = addr_of(row1, col1);

   assign in_bounds = (32'(wrow_ff) < MAX_ROWS) && (32'(wcol_ff) < MAX_FRAMES);
   assign wr_req    = a_valid_ff && (op_ff == OP_WRITE) && in_bounds;
   assign wr_addr   = addr_of({1'b0, wrow_ff}, {1'b0, wcol_ff});
   assign wr_data   = wval_ff;

   always_comb begin
      if (op_ff == OP_WRITE) begin
         a_ctrl.status = ST_WRITE;
      end else if (range_ff) begin
         a_ctrl.status = ST_RANGE;
      end else begin
         a_ctrl.status = ST_OK;
      end
      // Zero fractions turn the blend into a plain copy of the first tap.
      a_ctrl.fx = (cfg.mode == MODE_LINEAR) ? fx_ff : '0;
      a_ctrl.fz = (cfg.mode == MODE_LINEAR) ? zs_ff[FRAC_W-1:0] : '0;
   end

   assign a_valid = a_valid_ff;

   `WT2D_ASSERT_IMP(a_lookup_addr_in_table, clock, reset, a_valid_ff && (a_ctrl.status == ST_OK), (32'(rd_addr[0]) < DEPTH) && (32'(rd_addr[1]) < DEPTH) && (32'(rd_addr[2]) < DEPTH) && (32'(rd_addr[3]) < DEPTH), "lookup address beyond table")

endmodule

// ===== src/wt2d_table.sv =====
`timescale 1ns / 1ps
`include "wavetable_2d_bilinear_lookup_top_assert.svh"
module wt2d_table #(
   parameter int MAX_FRAMES = 1024,
   parameter int MAX_ROWS = 16,
   localparam int ADDR_W = $clog2(MAX_FRAMES * MAX_ROWS)
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        a_valid,
   output logic                                        a_ready,
   input  logic                                        wr_req,
   input  logic [ADDR_W-1:0]                           wr_addr,
   input  logic [wt2d_pkg::SAMPLE_W-1:0]               wr_data,
   input  logic [wt2d_pkg::TAPS-1:0][ADDR_W-1:0]       rd_addr,
   input  wt2d_pkg::ctrl_type                          a_ctrl,
   output logic                                        b_valid,
   input  logic                                        b_ready,
   output wt2d_pkg::ctrl_type                          b_ctrl,
   output logic [wt2d_pkg::TAPS-1:0][wt2d_pkg::SAMPLE_W-1:0] b_data
);

   import wt2d_pkg::*;

   logic     b_valid_ff;
   ctrl_type b_ctrl_ff;
   logic     adv;

   assign a_ready = !b_valid_ff || b_ready;
   assign adv     = a_valid && a_ready;

   // One copy of the table per tap; every write goes to all copies so that
   // the four neighbours can be read in the same cycle.
   for (genvar k = 0; k < TAPS; k++) begin : g_tap
      wt2d_ram #(
         .WIDTH (SAMPLE_W),
         .DEPTH (MAX_FRAMES * MAX_ROWS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (adv && wr_req),
         .wr_addr (wr_addr),
         .wr_data (wr_data),
         .rd_en   (adv),
         .rd_addr (rd_addr[k]),
         .rd_data (b_data[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (a_ready) begin
         b_valid_ff <= a_valid;
      end
      if (a_ready) begin
         b_ctrl_ff <= a_ctrl;
      end
   end

   assign b_valid = b_valid_ff;
   assign b_ctrl  = b_ctrl_ff;

   `WT2D_ASSERT_NEXT(b_stall_holds_data, clock, reset, b_valid_ff && !b_ready, b_valid_ff && $stable(b_data) && $stable(b_ctrl_ff), "table read data moved under stall")

endmodule

// ===== src/wt2d_blend.sv =====
`timescale 1ns / 1ps
`include "wavetable_2d_bilinear_lookup_top_assert.svh"
module wt2d_blend (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              b_valid,
   output logic                                              b_ready,
   input  wt2d_pkg::ctrl_type                                b_ctrl,
   input  logic [wt2d_pkg::TAPS-1:0][wt2d_pkg::SAMPLE_W-1:0] b_data,
   output logic                                              rsp_valid,
   input  logic                                              rsp_ready,
   output logic signed [wt2d_pkg::SAMPLE_W-1:0]              rsp_sample_out,
   output logic [wt2d_pkg::STATUS_W-1:0]                     rsp_status
);

   import wt2d_pkg::*;

   localparam int PROD_W = 34;
   localparam logic [FRAC_W:0] W_ONE = 17'h10000;

   logic ready_c, ready_d, ready_e, ready_f;

   logic                        c_valid_ff;
   logic                        d_valid_ff;
   logic                        e_valid_ff;
   logic                        rsp_valid_ff;

   assign ready_f = !rsp_valid_ff || rsp_ready;
   assign ready_e = !e_valid_ff || ready_f;
   assign ready_d = !d_valid_ff || ready_e;
   assign ready_c = !c_valid_ff || ready_d;
   assign b_ready = ready_c;

   // Stage C: first-level products along x for both rows.
   logic [FRAC_W:0]             wx;
   logic signed [PROD_W-1:0]    p0a_in, p0b_in, p1a_in, p1b_in;
   logic signed [PROD_W-1:0]    p0a_ff, p0b_ff, p1a_ff, p1b_ff;
   logic [FRAC_W-1:0]           c_fz_ff;
   status_type                  c_status_ff;

   assign wx     = W_ONE - {1'b0, b_ctrl.fx};
   assign p0a_in = $signed({1'b0, wx}) * $signed(b_data[0]);
   assign p0b_in = $signed({2'b0, b_ctrl.fx}) * $signed(b_data[1]);
   assign p1a_in = $signed({1'b0, wx}) * $signed(b_data[2]);
   assign p1b_in = $signed({2'b0, b_ctrl.fx}) * $signed(b_data[3]);

   // Stage D: sums floored back to Q1.15.
   logic signed [PROD_W-1:0]    sum0, sum1;
   logic signed [SAMPLE_W-1:0]  s0_ff, s1_ff;
   logic [FRAC_W-1:0]           d_fz_ff;
   status_type                  d_status_ff;

   assign sum0 = p0a_ff + p0b_ff;
   assign sum1 = p1a_ff + p1b_ff;

   // Stage E: second-level products along z.
   logic [FRAC_W:0]             wz;
   logic signed [PROD_W-1:0]    q0_in, q1_in;
   logic signed [PROD_W-1:0]    e_q0_ff, e_q1_ff;
   status_type                  e_status_ff;

   assign wz    = W_ONE - {1'b0, d_fz_ff};
   assign q0_in = $signed({1'b0, wz}) * s0_ff;
   assign q1_in = $signed({2'b0, d_fz_ff}) * s1_ff;

   // Output stage: final sum, forced to zero for writes and range errors.
   logic signed [PROD_W-1:0]    qsum;
   logic signed [SAMPLE_W-1:0]  sample_in;
   logic signed [SAMPLE_W-1:0]  rsp_sample_ff;
   status_type                  rsp_status_ff;

   assign qsum      = e_q0_ff + e_q1_ff;
   assign sample_in = (e_status_ff == ST_OK) ? qsum[31:16] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         e_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ready_c) begin
            c_valid_ff <= b_valid;
         end
         if (ready_d) begin
            d_valid_ff <= c_valid_ff;
         end
         if (ready_e) begin
            e_valid_ff <= d_valid_ff;
         end
         if (ready_f) begin
            rsp_valid_ff <= e_valid_ff;
         end
      end
      if (ready_c) begin
         p0a_ff      <= p0a_in;
         p0b_ff      <= p0b_in;
         p1a_ff      <= p1a_in;
         p1b_ff      <= p1b_in;
         c_fz_ff     <= b_ctrl.fz;
         c_status_ff <= b_ctrl.status;
      end
      if (ready_d) begin
         s0_ff       <= sum0[31:16];
         s1_ff       <= sum1[31:16];
         d_fz_ff     <= c_fz_ff;
         d_status_ff <= c_status_ff;
      end
      if (ready_e) begin
         e_q0_ff     <= q0_in;
         e_q1_ff     <= q1_in;
         e_status_ff <= d_status_ff;
      end
      if (ready_f) begin
         rsp_sample_ff <= sample_in;
         rsp_status_ff <= e_status_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_status     = rsp_status_ff;

   `WT2D_ASSERT_IMP(rsp_zero_unless_ok, clock, reset, rsp_valid_ff && (rsp_status_ff != ST_OK), rsp_sample_ff == '0, "nonzero sample on write or range beat")
   `WT2D_ASSERT_NEXT(e_stall_holds_products, clock, reset, e_valid_ff && !ready_f, e_valid_ff && $stable(e_q0_ff) && $stable(e_q1_ff), "z products moved under stall")

endmodule

// ===== src/wavetable_2d_bilinear_lookup_top.sv =====
`timescale 1ns / 1ps
// A request beat passes the stage A, B, C, D and E registers and the output register before its result beat is valid.
// Throughput: one request beat per cycle while rsp_ready is high, writes and lookups mixed freely.
// Backpressure on rsp_ready stalls the pipeline stage by stage; empty stages
// keep taking new beats while a finished result waits at the output.
// Reset (synchronous, active high) empties the pipeline and sets the registers
// to bilinear mode, 1024 frames, 16 rows; the table contents are not cleared.
module wavetable_2d_bilinear_lookup_top #(
   parameter int MAX_FRAMES = 1024,
   parameter int MAX_ROWS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_write_enable,
   input  logic [wt2d_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [wt2d_pkg::CSR_DATA_W-1:0]          csr_write_data,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic                                     req_operation,
   input  logic [wt2d_pkg::ROW_W-1:0]               req_write_row,
   input  logic [wt2d_pkg::COL_W-1:0]               req_write_column,
   input  logic signed [wt2d_pkg::SAMPLE_W-1:0]     req_write_value,
   input  logic [wt2d_pkg::POSX_W-1:0]              req_position_x,
   input  logic [wt2d_pkg::POSZ_W-1:0]              req_position_z,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [wt2d_pkg::SAMPLE_W-1:0]     rsp_sample_out,
   output logic [wt2d_pkg::STATUS_W-1:0]            rsp_status
);

   import wt2d_pkg::*;

   localparam int ADDR_W = $clog2(MAX_FRAMES * MAX_ROWS);

   // The count registers hold their effective values: zero reads as one, and
   // anything above the table size reads as the table size. The widths of the
   // register fields bound the limits as well.
   localparam logic [FRAMES_W-1:0] FRAMES_LIMIT =
      (MAX_FRAMES > 2047) ? 11'd2047 : FRAMES_W'(MAX_FRAMES);
   localparam logic [ROWS_W-1:0] ROWS_LIMIT =
      (MAX_ROWS > 31) ? 5'd31 : ROWS_W'(MAX_ROWS);
   localparam logic [FRAMES_W-1:0] FRAMES_RESET =
      (FRAMES_LIMIT < 11'd1024) ? FRAMES_LIMIT : 11'd1024;
   localparam logic [ROWS_W-1:0] ROWS_RESET =
      (ROWS_LIMIT < 5'd16) ? ROWS_LIMIT : 5'd16;

   function automatic logic [FRAMES_W-1:0] clamp_frames(input logic [FRAMES_W-1:0] v);
      if (v == '0) begin
         clamp_frames = 11'd1;
      end else if (v > FRAMES_LIMIT) begin
         clamp_frames = FRAMES_LIMIT;
      end else begin
         clamp_frames = v;
      end
   endfunction

   function automatic logic [ROWS_W-1:0] clamp_rows(input logic [ROWS_W-1:0] v);
      if (v == '0) begin
         clamp_rows = 5'd1;
      end else if (v > ROWS_LIMIT) begin
         clamp_rows = ROWS_LIMIT;
      end else begin
         clamp_rows = v;
      end
   endfunction

   // Configuration registers. Writes to an unused index are dropped.
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode   <= MODE_LINEAR;
         cfg_ff.frames <= FRAMES_RESET;
         cfg_ff.rows   <= ROWS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MODE: begin
               cfg_ff.mode <= csr_write_data[0];
            end
            CSR_FRAMES: begin
               cfg_ff.frames <= clamp_frames(csr_write_data);
            end
            CSR_ROWS: begin
               cfg_ff.rows <= clamp_rows(csr_write_data[ROWS_W-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   // Stage A (front): z is saturated and scaled by rows-1, the frame
   // position is split and range checked, and the neighbour frame and the
   // rounded frame are wrapped. From the stage A registers the front end
   // forms the four table addresses, or the single rounded address in
   // nearest mode, together with the write address for write beats.
   logic                             a_valid;
   logic                             a_ready;
   logic                             wr_req;
   logic [ADDR_W-1:0]                wr_addr;
   logic [SAMPLE_W-1:0]              wr_data;
   logic [TAPS-1:0][ADDR_W-1:0]      rd_addr;
   ctrl_type                         a_ctrl;

   wt2d_front #(
      .MAX_FRAMES (MAX_FRAMES),
      .MAX_ROWS   (MAX_ROWS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_write_row    (req_write_row),
      .req_write_column (req_write_column),
      .req_write_value  (req_write_value),
      .req_position_x   (req_position_x),
      .req_position_z   (req_position_z),
      .a_valid          (a_valid),
      .a_ready          (a_ready),
      .wr_req           (wr_req),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rd_addr          (rd_addr),
      .a_ctrl           (a_ctrl)
   );

   // Stage B (table): four replicated table copies, each with a registered
   // read port. Writes and reads happen as a beat leaves stage A, so a lookup
   // that follows a write always sees the written entry.
   logic                             b_valid;
   logic                             b_ready;
   ctrl_type                         b_ctrl;
   logic [TAPS-1:0][SAMPLE_W-1:0]    b_data;

   wt2d_table #(
      .MAX_FRAMES (MAX_FRAMES),
      .MAX_ROWS   (MAX_ROWS)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .a_valid (a_valid),
      .a_ready (a_ready),
      .wr_req  (wr_req),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .a_ctrl  (a_ctrl),
      .b_valid (b_valid),
      .b_ready (b_ready),
      .b_ctrl  (b_ctrl),
      .b_data  (b_data)
   );

   // Stages C through the output register (blend): x products, floored x
   // sums, z products, then the floored final sum. Each beat carries its own
   // fractions, so nearest mode simply passes the first tap through with
   // zero weights on the others.
   wt2d_blend u_blend (
      .clock          (clock),
      .reset          (reset),
      .b_valid        (b_valid),
      .b_ready        (b_ready),
      .b_ctrl         (b_ctrl),
      .b_data         (b_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_status     (rsp_status)
   );

endmodule

// ===== test/wt2d_tb_pkg.sv =====
`timescale 1ns / 1ps
package wt2d_tb_pkg;

   // Geometry of the table behind the default block parameters.
   localparam int TABLE_FRAMES = 1024;
   localparam int TABLE_ROWS   = 16;

   // Used only to size the drain wait of the testbench.
   localparam int PIPE_LATENCY = 5;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_LOOKUP = 1'b1
   } op_type;

   // A register value of zero acts as one, anything above the limit as the limit.
   function automatic int unsigned clamp_count(input int unsigned raw, input int unsigned limit);
      if (raw == 0) return 1;
      if (raw > limit) return limit;
      return raw;
   endfunction

endpackage

// ===== test/wt2d_lookup_checker.sv =====
`timescale 1ns / 1ps
module wt2d_lookup_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [wt2d_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [wt2d_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic                                 req_operation,
   input  logic [wt2d_pkg::ROW_W-1:0]           req_write_row,
   input  logic [wt2d_pkg::COL_W-1:0]           req_write_column,
   input  logic signed [wt2d_pkg::SAMPLE_W-1:0] req_write_value,
   input  logic [wt2d_pkg::POSX_W-1:0]          req_position_x,
   input  logic [wt2d_pkg::POSZ_W-1:0]          req_position_z,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [wt2d_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input  logic [wt2d_pkg::STATUS_W-1:0]        rsp_status,
   output int                                   mismatch_count,
   output int                                   outstanding
);
   import wt2d_pkg::*;
   import wt2d_tb_pkg::*;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      status_type                 status;
   } lookup_result_type;

   lookup_result_type          lookup_result_q[$];
   logic signed [SAMPLE_W-1:0] table_shadow [TABLE_ROWS*TABLE_FRAMES];
   logic                       mode_q;
   int unsigned                frames_q;
   int unsigned                rows_q;

   function automatic int table_entry(input int unsigned row, input int unsigned col);
      return table_shadow[row*TABLE_FRAMES + col];
   endfunction

   // floor(((1 - f) * a + f * b)) with f in Q0.16.
   function automatic logic signed [SAMPLE_W-1:0] blend_q15(input int a, input int b,
                                                            input int unsigned f);
      longint fl;
      longint acc;
      fl  = longint'(f);
      acc = (longint'(65536) - fl) * a + fl * b;
      return acc[31:16];
   endfunction

   // Works out the result of one request beat and applies table writes.
   function automatic lookup_result_type compute_lookup_result(
      input logic                       op,
      input logic [ROW_W-1:0]           row,
      input logic [COL_W-1:0]           col,
      input logic signed [SAMPLE_W-1:0] value,
      input logic [POSX_W-1:0]          px,
      input logic [POSZ_W-1:0]          pz);
      lookup_result_type res;
      int unsigned xi, fx, pzs, zs, zi, fz, xn, zr, zn, xr;
      int s0, s1;
      res.sample = '0;
      if (op == OP_WRITE) begin
         table_shadow[row*TABLE_FRAMES + col] = value;
         res.status = ST_WRITE;
      end else begin
         xi  = px >> FRAC_W;
         fx  = px[FRAC_W-1:0];
         pzs = (pz > 65536) ? 65536 : pz;
         zs  = pzs * (rows_q - 1);
         zi  = zs >> FRAC_W;
         fz  = zs & 32'hFFFF;
         if (xi >= frames_q) begin
            res.status = ST_RANGE;
         end else if (mode_q == MODE_LINEAR) begin
            xn = (xi + 1 >= frames_q) ? 0 : xi + 1;
            zr = zi % rows_q;
            zn = (zr + 1 >= rows_q) ? 0 : zr + 1;
            s0 = blend_q15(table_entry(zr, xi), table_entry(zr, xn), fx);
            s1 = blend_q15(table_entry(zn, xi), table_entry(zn, xn), fx);
            res.sample = blend_q15(s0, s1, fz);
            res.status = ST_OK;
         end else begin
            xr = (32'(px) + 32'h8000) >> FRAC_W;
            if (xr >= frames_q) xr = 0;
            zr = ((zs + 32'h8000) >> FRAC_W) % rows_q;
            res.sample = table_shadow[zr*TABLE_FRAMES + xr];
            res.status = ST_OK;
         end
      end
      return res;
   endfunction

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
   endtask

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   always @(posedge clock) begin
      lookup_result_type oldest;
      if (reset) begin
         lookup_result_q.delete();
         mode_q   = MODE_LINEAR;
         frames_q = TABLE_FRAMES;
         rows_q   = TABLE_ROWS;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MODE:   mode_q = csr_write_data[0];
               CSR_FRAMES: frames_q = clamp_count(csr_write_data, TABLE_FRAMES);
               CSR_ROWS:   rows_q = clamp_count(csr_write_data[ROWS_W-1:0], TABLE_ROWS);
               default: ;
            endcase
         end
         // The result beat is always older than a request beat of the same edge.
         if (rsp_valid && rsp_ready) begin
            if (lookup_result_q.size() == 0) begin
               note_mismatch($sformatf("unexpected result beat: sample %0d status %0d",
                                       rsp_sample_out, rsp_status));
            end else begin
               oldest = lookup_result_q.pop_front();
               if (rsp_sample_out !== oldest.sample || rsp_status !== oldest.status)
                  note_mismatch($sformatf(
                     "result beat: expected sample %0d status %0d, got sample %0d status %0d",
                     oldest.sample, oldest.status, rsp_sample_out, rsp_status));
            end
         end
         if (req_valid && req_ready)
            lookup_result_q.push_back(compute_lookup_result(req_operation, req_write_row,
               req_write_column, req_write_value, req_position_x, req_position_z));
      end
      outstanding = lookup_result_q.size();
   end

endmodule

// ===== test/tb_wavetable_2d_bilinear_lookup_top.sv =====
`timescale 1ns / 1ps
module tb_wavetable_2d_bilinear_lookup_top;
   import wt2d_pkg::*;
   import wt2d_tb_pkg::*;

   // The only index that maps to no register.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   // Long enough for the pipeline to fill up and push back on the request side.
   localparam int HOLD_OFF_CYCLES = 300;
   // Settling time after the last result before a register write or the verdict.
   localparam int DRAIN_CYCLES = 2 * PIPE_LATENCY;
   localparam int RANDOM_BEATS = 1750;
   localparam int RANDOM_PHASES = 8;

   typedef struct {
      op_type                     operation;
      logic [ROW_W-1:0]           write_row;
      logic [COL_W-1:0]           write_column;
      logic signed [SAMPLE_W-1:0] write_value;
      logic [POSX_W-1:0]          position_x;
      logic [POSZ_W-1:0]          position_z;
   } request_beat_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]      csr_write_data;
   logic                       req_valid;
   logic                       req_ready;
   logic                       req_operation;
   logic [ROW_W-1:0]           req_write_row;
   logic [COL_W-1:0]           req_write_column;
   logic signed [SAMPLE_W-1:0] req_write_value;
   logic [POSX_W-1:0]          req_position_x;
   logic [POSZ_W-1:0]          req_position_z;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic [STATUS_W-1:0]        rsp_status;

   int mismatch_count;
   int outstanding;

   // Stimulus bookkeeping. The table is never cleared, so a lookup may only touch
   // entries that some earlier write beat has filled in.
   bit          written_map [TABLE_ROWS*TABLE_FRAMES];
   int unsigned cur_frames;
   int unsigned cur_rows;
   int unsigned window_base;
   int          beats_sent;
   bit          sender_idles;
   bit          receiver_idles;
   bit          hold_off_request;

   always #1 clock = ~clock;

   wavetable_2d_bilinear_lookup_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_write_row    (req_write_row),
      .req_write_column (req_write_column),
      .req_write_value  (req_write_value),
      .req_position_x   (req_position_x),
      .req_position_z   (req_position_z),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_status       (rsp_status)
   );

   wt2d_lookup_checker i_lookup_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_write_row    (req_write_row),
      .req_write_column (req_write_column),
      .req_write_value  (req_write_value),
      .req_position_x   (req_position_x),
      .req_position_z   (req_position_z),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_status       (rsp_status),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   // Every field random; the caller then sets what matters for the beat. The fields
   // that a beat ignores keep their random noise.
   function automatic request_beat_type random_beat();
      request_beat_type b;
      b.operation    = op_type'($urandom_range(0, 1));
      b.write_row    = ROW_W'($urandom);
      b.write_column = COL_W'($urandom);
      b.write_value  = SAMPLE_W'($urandom);
      b.position_x   = POSX_W'($urandom);
      b.position_z   = POSZ_W'($urandom);
      return b;
   endfunction

   // Samples lean toward full scale and zero now and then.
   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 7))
         0:       return SAMPLE_W'(-32768);
         1:       return SAMPLE_W'(32767);
         2:       return '0;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Table indexes that a lookup can read under the current settings: the four
   // bilinear neighbours plus the nearest entry. Returns how many were filled in.
   function automatic int lookup_footprint(input logic [POSX_W-1:0] px,
                                           input logic [POSZ_W-1:0] pz,
                                           output int unsigned cells [5]);
      int unsigned xi, pzs, zs, zr, zn, xn, xr, zq;
      xi = px >> FRAC_W;
      if (xi >= cur_frames) return 0;
      pzs = (pz > 65536) ? 65536 : pz;
      zs  = pzs * (cur_rows - 1);
      zr  = (zs >> FRAC_W) % cur_rows;
      zn  = (zr + 1 >= cur_rows) ? 0 : zr + 1;
      xn  = (xi + 1 >= cur_frames) ? 0 : xi + 1;
      xr  = (32'(px) + 32'h8000) >> FRAC_W;
      if (xr >= cur_frames) xr = 0;
      zq  = ((zs + 32'h8000) >> FRAC_W) % cur_rows;
      cells[0] = zr*TABLE_FRAMES + xi;
      cells[1] = zr*TABLE_FRAMES + xn;
      cells[2] = zn*TABLE_FRAMES + xi;
      cells[3] = zn*TABLE_FRAMES + xn;
      cells[4] = zq*TABLE_FRAMES + xr;
      return 5;
   endfunction

   // Offers one beat, after a random gap while the sender idles, and returns on the edge that accepts it.
   // Valid is left high so that back-to-back beats never drop it in between.
   task automatic send_beat(input request_beat_type b);
      int gap;
      gap = sender_idles ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= b.operation;
      req_write_row    <= b.write_row;
      req_write_column <= b.write_column;
      req_write_value  <= b.write_value;
      req_position_x   <= b.position_x;
      req_position_z   <= b.position_z;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   task automatic write_entry(input int unsigned row, input int unsigned col,
                              input logic signed [SAMPLE_W-1:0] value);
      request_beat_type b;
      b              = random_beat();
      b.operation    = OP_WRITE;
      b.write_row    = ROW_W'(row);
      b.write_column = COL_W'(col);
      b.write_value  = value;
      written_map[row*TABLE_FRAMES + col] = 1'b1;
      send_beat(b);
   endtask

   // Fills in any entry the lookup could touch that was never written, then
   // sends the lookup itself.
   task automatic lookup(input logic [POSX_W-1:0] px, input logic [POSZ_W-1:0] pz);
      request_beat_type b;
      int unsigned      cells [5];
      int               n;
      n = lookup_footprint(px, pz, cells);
      for (int i = 0; i < n; i++)
         if (!written_map[cells[i]])
            write_entry(cells[i] / TABLE_FRAMES, cells[i] % TABLE_FRAMES, random_sample());
      b            = random_beat();
      b.operation  = OP_LOOKUP;
      b.position_x = px;
      b.position_z = pz;
      send_beat(b);
   endtask

   // Positions crowd around the last frame, a small window and the rounding
   // midpoints, with some out of range when the row is short enough.
   task automatic random_lookup();
      int unsigned xi, fx, pz;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 10 && cur_frames < TABLE_FRAMES)
         xi = $urandom_range(cur_frames, TABLE_FRAMES - 1);
      else if (pick < 25)
         xi = cur_frames - 1;
      else if (pick < 60)
         xi = (window_base + $urandom_range(0, 3)) % cur_frames;
      else
         xi = $urandom_range(0, cur_frames - 1);
      case ($urandom_range(0, 11))
         0:       fx = 16'h0000;
         1:       fx = 16'h7FFF;
         2:       fx = 16'h8000;
         3:       fx = 16'hFFFF;
         default: fx = $urandom_range(0, 16'hFFFF);
      endcase
      case ($urandom_range(0, 9))
         0:       pz = $urandom_range(65537, 131071);
         1:       pz = $urandom_range(0, 1) ? 65536 : 0;
         default: pz = $urandom_range(0, 65536);
      endcase
      lookup({xi[COL_W-1:0], fx[FRAC_W-1:0]}, POSZ_W'(pz));
   endtask

   task automatic random_step();
      int unsigned col;
      if ($urandom_range(0, 99) < 15) begin
         col = $urandom_range(0, 1) ? (window_base + $urandom_range(0, 4)) % TABLE_FRAMES
                                    : $urandom_range(0, TABLE_FRAMES - 1);
         write_entry($urandom_range(0, TABLE_ROWS - 1), col, random_sample());
      end else begin
         random_lookup();
      end
      if ($urandom_range(0, 49) == 0) sender_idles = !sender_idles;
   endtask

   // Stops offering beats and waits until every result has been taken.
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register writes happen only with the block empty. Bits above a register's
   // width carry noise that the block must drop.
   task automatic apply_config(input logic mode_bit, input logic [CSR_DATA_W-1:0] frames_raw,
                               input logic [ROWS_W-1:0] rows_raw, input bit poke_unmapped);
      drain();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_MODE;
      csr_write_data   <= {(CSR_DATA_W-1)'($urandom), mode_bit};
      @(posedge clock);
      csr_index      <= CSR_FRAMES;
      csr_write_data <= frames_raw;
      @(posedge clock);
      csr_index      <= CSR_ROWS;
      csr_write_data <= {(CSR_DATA_W-ROWS_W)'($urandom), rows_raw};
      @(posedge clock);
      if (poke_unmapped) begin
         csr_index      <= CSR_UNMAPPED;
         csr_write_data <= CSR_DATA_W'($urandom);
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      cur_frames = clamp_count(frames_raw, TABLE_FRAMES);
      cur_rows   = clamp_count(rows_raw, TABLE_ROWS);
   endtask

   // Result side: a random stall before each beat, stretches without stalls, and
   // one long hold-off when the stimulus asks for it.
   initial begin : rsp_side
      int gap;
      rsp_ready      = 1'b0;
      receiver_idles = 1'b1;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
         end
         if ($urandom_range(0, 39) == 0) receiver_idles = !receiver_idles;
         gap = receiver_idles ? $urandom_range(0, 19) : 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Run limit, several times the slowest legal run.
   initial begin
      #1000000;
      $display("** wavetable_2d_bilinear_lookup_top: FAILED **");
      $finish;
   end

   initial begin
      int phase_end;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_MODE;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_operation    = OP_WRITE;
      req_write_row    = '0;
      req_write_column = '0;
      req_write_value  = '0;
      req_position_x   = '0;
      req_position_z   = '0;
      cur_frames       = TABLE_FRAMES;
      cur_rows         = TABLE_ROWS;
      window_base      = 0;
      beats_sent       = 0;
      sender_idles     = 1'b1;
      hold_off_request = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset settings: bilinear, 1024 frames, 16 rows.
      // Full-scale corners first, then a blend halfway between the first two of them.
      write_entry(0, 0, SAMPLE_W'(32767));
      write_entry(0, 1, SAMPLE_W'(-32768));
      write_entry(1, 0, SAMPLE_W'(-32768));
      write_entry(1, 1, SAMPLE_W'(32767));
      lookup(26'h0008000, 17'd0);
      // Both fractions at their largest; 4369 * 15 lands just below row one.
      lookup(26'h000FFFF, 17'd4369);
      // Last frame and last row, where the next frame and next row wrap to zero.
      write_entry(TABLE_ROWS - 1, TABLE_FRAMES - 1, SAMPLE_W'(-32768));
      write_entry(TABLE_ROWS - 1, 0, SAMPLE_W'(32767));
      lookup(26'h3FFFFFF, 17'd65536);
      // Row position beyond one saturates.
      lookup(26'h3FFFFFF, 17'h1FFFF);

      // Nearest mode: rounding past the last frame wraps to frame zero.
      apply_config(MODE_NEAREST, 11'd1024, 5'd16, 1'b1);
      lookup({10'd1023, 16'h8000}, 17'd65536);
      lookup(26'h0007FFF, 17'd2184);

      // Zero in the count registers acts as one.
      apply_config(MODE_LINEAR, 11'd0, 5'd0, 1'b0);
      lookup(26'h000FFFF, 17'd65536);
      lookup(26'h0010000, 17'd0);
      apply_config(MODE_NEAREST, 11'd0, 5'd0, 1'b0);
      lookup(26'h000FFFF, 17'd0);

      // Counts above the table size act as the table size.
      apply_config(MODE_LINEAR, 11'd2047, 5'd31, 1'b1);
      lookup(26'h3FFFFFF, 17'd65536);

      // A short row: frame positions at or past the end are out of range.
      apply_config(MODE_LINEAR, 11'd5, 5'd3, 1'b0);
      lookup({10'd5, 16'h0000}, 17'd0);
      lookup(26'h3FFFFFF, 17'd100);
      lookup({10'd4, 16'hC000}, 17'd32768);

      // Back-pressure: the result side holds off while beats keep coming with no
      // gaps, so the pipeline fills and request ready drops.
      apply_config(MODE_LINEAR, 11'd64, 5'd8, 1'b0);
      window_base      = $urandom_range(0, 63);
      sender_idles     = 1'b0;
      hold_off_request = 1'b1;
      repeat (40) random_lookup();
      drain();

      // Random phases, each under its own settings; every change drains first.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         logic [CSR_DATA_W-1:0] frames_raw;
         logic [ROWS_W-1:0]     rows_raw;
         case ($urandom_range(0, 7))
            0:       frames_raw = 11'd0;
            1:       frames_raw = 11'd1;
            2:       frames_raw = 11'd2;
            3:       frames_raw = 11'd1024;
            4:       frames_raw = 11'd2047;
            5:       frames_raw = CSR_DATA_W'($urandom_range(1025, 2047));
            default: frames_raw = CSR_DATA_W'($urandom_range(1, 1024));
         endcase
         case ($urandom_range(0, 7))
            0:       rows_raw = 5'd0;
            1:       rows_raw = 5'd1;
            2:       rows_raw = 5'd2;
            3:       rows_raw = 5'd16;
            4:       rows_raw = 5'd31;
            5:       rows_raw = ROWS_W'($urandom_range(17, 31));
            default: rows_raw = ROWS_W'($urandom_range(1, 16));
         endcase
         apply_config($urandom_range(0, 1) ? MODE_LINEAR : MODE_NEAREST, frames_raw, rows_raw,
                      $urandom_range(0, 3) == 0);
         window_base  = $urandom_range(0, TABLE_FRAMES - 1);
         sender_idles = ($urandom_range(0, 3) != 0);
         phase_end    = beats_sent + RANDOM_BEATS / RANDOM_PHASES;
         while (beats_sent < phase_end) random_step();
      end

      drain();
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("** wavetable_2d_bilinear_lookup_top: PASSED **");
      end else begin
         $display("** wavetable_2d_bilinear_lookup_top: FAILED **");
      end
      $finish;
   end

endmodule

// ===== wavetable_2d_bilinear_lookup_top.f =====
+incdir+src
src/wt2d_pkg.sv
src/wt2d_ram.sv
src/wt2d_front.sv
src/wt2d_table.sv
src/wt2d_blend.sv
src/wavetable_2d_bilinear_lookup_top.sv
test/wt2d_tb_pkg.sv
test/wt2d_lookup_checker.sv
test/tb_wavetable_2d_bilinear_lookup_top.sv
